>>> sv/humidity_temperature_conversion_core_assert.svh
// Assertion macros for the humidity/temperature conversion core
`ifndef HUMIDITY_TEMPERATURE_CONVERSION_CORE_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_CONVERSION_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset
`define HTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must hold whenever a result is presented
`define HTC_ASSERT_ON_DONE(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) done |-> (cond)) \
        else $error(msg);

`endif

>>> sv/htc_pkg.sv
// Shared types and constants for the humidity/temperature conversion core
package htc_pkg;

    typedef struct packed {
        logic [13:0] temp_ticks;
        logic [11:0] hum_ticks;
    } htc_req_t;

    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
    } htc_rsp_t;

    // Width of the humidity numerator datapath
    localparam int unsigned SUM_W = 33;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam logic signed [14:0] TEMP_OFFSET   = 15'sd3960;
    localparam logic signed [15:0] TEMP_REF      = 16'sd2500;
    localparam logic [15:0]        COMP_BASE     = 16'd1000;

    localparam sum_t HUM_LIN_COEF  = 33'sd405000;
    localparam sum_t HUM_QUAD_COEF = 33'sd28;
    // -40000000 offset with the +50000 rounding term folded in
    localparam sum_t HUM_OFFSET    = 33'sd39950000;

    // Clamp limits on the rounded numerator (N + 50000)
    localparam sum_t HUM_HI_LIMIT  = 33'sd1000100000;
    localparam sum_t HUM_LO_LIMIT  = 33'sd1000000;

    localparam logic [13:0] HUM_MAX_CENTI = 14'd10000;
    localparam logic [13:0] HUM_MIN_CENTI = 14'd10;

    // floor(x / 3125) == (x * RECIP) >> RECIP_SHIFT for x < 2^25
    localparam int unsigned RECIP_SHIFT = 37;
    localparam logic [25:0] RECIP       = 26'd43980466;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_HI   = 2'd1;
    localparam logic [1:0] CLAMP_LO   = 2'd2;

endpackage

>>> sv/humidity_temperature_conversion_core.sv
// Top level: pipelined raw tick to temperature / compensated humidity conversion
//
//  channel   direction  handshake               payload
//  request   in         start (busy always 0)   request : htc_req_t
//  result    out        done strobe, 1 cycle    result  : htc_rsp_t
//
// Seven register stages lie between a request and its result.
// One request per cycle is taken; the multiplier stages set the depth.
// Reset clears only the valid bits of the stages; data registers are free.
// The receiver cannot stall, so the pipeline never stalls and busy stays low.
`include "humidity_temperature_conversion_core_assert.svh"

module humidity_temperature_conversion_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  htc_pkg::htc_req_t request,
    output logic             done,
    output htc_pkg::htc_rsp_t result
);

    localparam int unsigned LATENCY = 7;

    logic [LATENCY-1:0] vld_reg;
    logic               accept;

    // temperature rides along the pipe
    logic signed [14:0] tc_reg [LATENCY];

    // stage 1
    logic signed [14:0] tc_next;
    logic signed [15:0] dt1_reg, dt1_next;
    logic [15:0]        w1_reg, w1_next;
    logic [11:0]        h1_reg;
    // stage 2
    logic [23:0]        hsq2_reg;
    htc_pkg::sum_t      prod2_reg, prod2_next;
    htc_pkg::sum_t      lin2_reg, lin2_next;
    // stage 3
    htc_pkg::sum_t      quad3_reg, quad3_next;
    htc_pkg::sum_t      prod3_reg;
    // stage 4
    htc_pkg::sum_t      m4_reg;
    // stage 5
    logic [24:0]        x5_reg;
    logic [1:0]         clamp5_reg, clamp5_next;
    // stage 6
    logic [50:0]        q6_reg;
    logic [1:0]         clamp6_reg;
    // stage 7
    logic [13:0]        hum7_reg, hum7_next;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], accept};
        end
    end

    assign tc_next  = $signed({1'b0, request.temp_ticks}) - htc_pkg::TEMP_OFFSET;
    assign dt1_next = $signed({tc_next[14], tc_next}) - htc_pkg::TEMP_REF;
    assign w1_next  = htc_pkg::COMP_BASE + {1'b0, request.hum_ticks, 3'b000};

    assign prod2_next = htc_pkg::sum_t'(dt1_reg) * htc_pkg::sum_t'($signed({1'b0, w1_reg}));
    assign lin2_next  = htc_pkg::sum_t'($signed({1'b0, h1_reg})) * htc_pkg::HUM_LIN_COEF
                        - htc_pkg::HUM_OFFSET;

    assign quad3_next = lin2_reg
                        - htc_pkg::sum_t'($signed({1'b0, hsq2_reg})) * htc_pkg::HUM_QUAD_COEF;

    always_comb
    begin
        if (m4_reg >= htc_pkg::HUM_HI_LIMIT)
        begin
            clamp5_next = htc_pkg::CLAMP_HI;
        end
        else if (m4_reg < htc_pkg::HUM_LO_LIMIT)
        begin
            clamp5_next = htc_pkg::CLAMP_LO;
        end
        else
        begin
            clamp5_next = htc_pkg::CLAMP_NONE;
        end
    end

    always_comb
    begin
        case (clamp6_reg)
            htc_pkg::CLAMP_HI: hum7_next = htc_pkg::HUM_MAX_CENTI;
            htc_pkg::CLAMP_LO: hum7_next = htc_pkg::HUM_MIN_CENTI;
            default:           hum7_next = q6_reg[htc_pkg::RECIP_SHIFT +: 14];
        endcase
    end

    always_ff @(posedge clk)
    begin
        tc_reg[0] <= tc_next;
        for (int i = 1; i < LATENCY; i++)
        begin
            tc_reg[i] <= tc_reg[i-1];
        end

        dt1_reg    <= dt1_next;
        w1_reg     <= w1_next;
        h1_reg     <= request.hum_ticks;

        hsq2_reg   <= {12'd0, h1_reg} * {12'd0, h1_reg};
        prod2_reg  <= prod2_next;
        lin2_reg   <= lin2_next;

        quad3_reg  <= quad3_next;
        prod3_reg  <= prod2_reg;

        m4_reg     <= quad3_reg + prod3_reg;

        // in the unclamped range the numerator is positive and below 2^30
        x5_reg     <= m4_reg[29:5];
        clamp5_reg <= clamp5_next;

        q6_reg     <= {26'd0, x5_reg} * {25'd0, htc_pkg::RECIP};
        clamp6_reg <= clamp5_reg;

        hum7_reg   <= hum7_next;
    end

    assign done              = vld_reg[LATENCY-1];
    assign result.temp_centi = tc_reg[LATENCY-1];
    assign result.hum_centi  = hum7_reg;

    `HTC_ASSERT(a_latency, start |-> ##7 done, "request did not produce a result after 7 cycles")
    `HTC_ASSERT(a_never_busy, !busy, "busy raised on a pipeline that cannot stall")
    `HTC_ASSERT_ON_DONE(a_hum_range,
        result.hum_centi >= htc_pkg::HUM_MIN_CENTI && result.hum_centi <= htc_pkg::HUM_MAX_CENTI,
        "humidity result outside clamp range")
    `HTC_ASSERT_ON_DONE(a_temp_range, result.temp_centi >= -15'sd3960,
        "temperature result below offset")

endmodule

>>> bench/htc_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the humidity/temperature conversion core: predicts and checks each result
module htc_scoreboard
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  htc_pkg::htc_req_t request,
    input  logic              done,
    input  htc_pkg::htc_rsp_t result,
    output int                errors,
    output int                pending
);

    localparam longint TICK_OFFSET   = 3960;
    localparam longint REF_CENTI     = 2500;
    localparam longint NUM_SCALE     = 100000;
    localparam longint NUM_HALF      = 50000;
    localparam longint RH_CEIL_CENTI = 10000;
    localparam longint RH_FLOOR_CENTI = 10;

    htc_pkg::htc_rsp_t expected_readings[$];
    htc_pkg::htc_rsp_t want;

    // Exact scaled-integer conversion of one sample pair
    function automatic htc_pkg::htc_rsp_t convert_sample(input htc_pkg::htc_req_t req);
        longint            t_c;
        longint            h;
        longint            num;
        longint            rh;
        htc_pkg::htc_rsp_t rsp;
        t_c = req.temp_ticks;
        t_c = t_c - TICK_OFFSET;
        h   = req.hum_ticks;
        num = -28 * h * h + 405000 * h - 40000000 + (t_c - REF_CENTI) * (1000 + 8 * h);
        num = num + NUM_HALF;
        // floor division; SV division truncates toward zero
        rh = num / NUM_SCALE;
        if ((num % NUM_SCALE) != 0 && num < 0)
            rh = rh - 1;
        if (rh > RH_CEIL_CENTI)
            rh = RH_CEIL_CENTI;
        if (rh < RH_FLOOR_CENTI)
            rh = RH_FLOOR_CENTI;
        rsp.temp_centi = t_c[14:0];
        rsp.hum_centi  = rh[13:0];
        return rsp;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($isunknown(done))
                report_mismatch("done strobe unknown");
            else if (done)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_readings.pop_front();
                    if (result.temp_centi !== want.temp_centi)
                        report_mismatch($sformatf("temp_centi got %0d expected %0d",
                                                  result.temp_centi, want.temp_centi));
                    if (result.hum_centi !== want.hum_centi)
                        report_mismatch($sformatf("hum_centi got %0d expected %0d",
                                                  result.hum_centi, want.hum_centi));
                end
            end
            if (start && !busy)
                expected_readings.push_back(convert_sample(request));
            pending = expected_readings.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Testbench top: drives sample requests into the conversion core and gives the verdict
module tb;

    localparam int RANDOM_REQUESTS = 1530;
    localparam int DRAIN_CYCLES    = 20;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    htc_pkg::htc_req_t request = '0;
    logic              busy;
    logic              done;
    htc_pkg::htc_rsp_t result;
    int                errors;
    int                pending;
    int                burst_left = 0;

    always #5 clk = ~clk;

    humidity_temperature_conversion_core uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    htc_scoreboard checker_i
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    // Mostly short gaps, a few long ones, and back-to-back bursts
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_sample(input logic [13:0] t_ticks, input logic [11:0] h_ticks);
        int gap;
        request <= '{temp_ticks: t_ticks, hum_ticks: h_ticks};
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int          mode;
        logic [13:0] t_ticks;
        logic [11:0] h_ticks;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes
        send_sample(14'd0, 12'd0);
        send_sample(14'd16383, 12'd4095);
        send_sample(14'd0, 12'd4095);
        send_sample(14'd16383, 12'd0);
        // reference temperature, no compensation
        send_sample(14'd6460, 12'd0);
        send_sample(14'd6460, 12'd2000);
        send_sample(14'd6460, 12'd4095);
        // exact halves round up
        send_sample(14'd6510, 12'd1000);
        send_sample(14'd6410, 12'd1000);
        // around the low clamp
        send_sample(14'd6460, 12'd100);
        send_sample(14'd6460, 12'd101);
        send_sample(14'd6460, 12'd102);
        // around the high clamp
        send_sample(14'd6460, 12'd3330);
        send_sample(14'd6460, 12'd3338);
        send_sample(14'd6460, 12'd3345);
        // zero Celsius and temperature sign boundary
        send_sample(14'd3960, 12'd1500);
        send_sample(14'd3959, 12'd1500);
        send_sample(14'd3961, 12'd2500);
        send_sample(14'd10000, 12'd3000);
        send_sample(14'd1000, 12'd3500);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            mode = $urandom_range(0, 9);
            t_ticks = 14'($urandom_range(0, 16383));
            h_ticks = 12'($urandom_range(0, 4095));
            case (mode)
                6: h_ticks = 12'($urandom_range(3000, 4095));
                7: h_ticks = 12'($urandom_range(0, 200));
                8: t_ticks = 14'($urandom_range(6000, 7000));
                9:
                begin
                    t_ticks = 14'($urandom_range(8000, 16383));
                    h_ticks = 12'($urandom_range(2800, 3600));
                end
                default: ;
            endcase
            send_sample(t_ticks, h_ticks);
        end
        start <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
